// ===== sv/emgwf_pkg.sv =====
// ----------------------------------------------------------------------------
// emgwf_pkg
// Shared constants, register indexes and helpers of the EMG window feature
// extractor.
// ----------------------------------------------------------------------------
package emgwf_pkg;

  localparam int WINDOW_MAX_DEF = 256;
  localparam int CHANNELS_DEF   = 8;
  localparam int PORT_CHANNELS  = 8;

  localparam int SAMPLE_W   = 8;
  localparam int LABEL_W    = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_HALF  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WLEN_RESET = 9'd64;

  // |x| of a signed byte; -128 maps to 128
  function automatic logic [SAMPLE_W-1:0] abs8(input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] r;
    r = b[SAMPLE_W-1] ? (~b + 1'b1) : b;
    return r;
  endfunction

endpackage

// ===== sv/emgwf_div.sv =====
// ----------------------------------------------------------------------------
// emgwf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emgwf_div #(
  parameter int DW = 48,
  parameter int VW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     rem_sh;
  logic            ge;

  assign rem_sh   = {rem, quo[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          quo  <= dividend;
          dvs  <= divisor;
          rem  <= '0;
          cnt  <= CNTW'(DW);
        end
      end else begin
        rem <= ge ? VW'(rem_sh - {1'b0, dvs}) : rem_sh[VW-1:0];
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

// ===== sv/emgwf_sqrt.sv =====
// ----------------------------------------------------------------------------
// emgwf_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module emgwf_sqrt #(
  parameter int SW = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SW-1:0]   radicand,
  output logic            busy,
  output logic            done,
  output logic [SW/2-1:0] root
);

  localparam int RW   = SW / 2;
  localparam int CNTW = $clog2(RW + 1);

  logic [SW-1:0]   rad;
  logic [RW:0]     rem;
  logic [CNTW-1:0] cnt;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic            ge;

  assign rem_sh = {rem, rad[SW-1:SW-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          rad  <= radicand;
          rem  <= '0;
          root <= '0;
          cnt  <= CNTW'(RW);
        end
      end else begin
        rem  <= ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
        root <= {root[RW-2:0], ge};
        rad  <= {rad[SW-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/emgwf_front.sv =====
// ----------------------------------------------------------------------------
// emgwf_front
// Sample intake: ring store, fill tracking, window detection and job queue.
// ----------------------------------------------------------------------------
module emgwf_front import emgwf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int CHANNELS   = CHANNELS_DEF,
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int NW = $clog2(WINDOW_MAX + 1),
  localparam int EW = SAMPLE_W * CHANNELS + LABEL_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_W*PORT_CHANNELS-1:0] samples,
  input  logic [LABEL_W-1:0]                label,
  input  logic [CFG_DATA_W-1:0]             window_length,
  input  logic                              overlap_half,
  output logic                              job_valid,
  output logic [AW-1:0]                     job_start,
  output logic [NW-1:0]                     job_n,
  input  logic                              job_pop,
  input  logic                              reading,
  input  logic [AW-1:0]                     rd_addr,
  output logic [EW-1:0]                     rd_data
);

  localparam int LW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;

  logic [EW-1:0] mem [WINDOW_MAX];
  logic [AW-1:0] window_start;
  logic [NW-1:0] fill_count;

  logic [AW-1:0] q_start [2];
  logic [NW-1:0] q_n     [2];
  logic          wp, rp;
  logic [1:0]    q_count;

  logic          accept;
  logic [NW:0]   pos_sum;
  logic [AW-1:0] pos;
  logic [NW-1:0] n_cur;
  logic [NW-1:0] half;
  logic [LW-1:0] wl_ext;
  logic [NW-1:0] eff_len;
  logic          trigger;
  logic [NW:0]   start_sum;
  logic [AW-1:0] start_wrap;
  logic          push;

  assign in_ready = (q_count == 2'd0) && !reading;
  assign accept   = in_valid && in_ready;

  assign pos_sum = (NW+1)'(window_start) + (NW+1)'(fill_count);
  assign pos     = (pos_sum >= (NW+1)'(WINDOW_MAX)) ?
                   AW'(pos_sum - (NW+1)'(WINDOW_MAX)) : AW'(pos_sum);
  assign n_cur   = fill_count + 1'b1;
  assign half    = n_cur >> 1;

  always_comb begin
    wl_ext = LW'(window_length);
    if (wl_ext < LW'(2)) begin
      eff_len = NW'(2);
    end else if (wl_ext > LW'(WINDOW_MAX)) begin
      eff_len = NW'(WINDOW_MAX);
    end else begin
      eff_len = NW'(wl_ext);
    end
  end

  assign trigger    = n_cur >= eff_len;
  assign push       = accept && trigger;
  assign start_sum  = (NW+1)'(window_start) + (NW+1)'(half);
  assign start_wrap = (start_sum >= (NW+1)'(WINDOW_MAX)) ?
                      AW'(start_sum - (NW+1)'(WINDOW_MAX)) : AW'(start_sum);

  assign job_valid = q_count != 2'd0;
  assign job_start = q_start[rp];
  assign job_n     = q_n[rp];

  // store and read port
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[pos] <= {label, samples[SAMPLE_W*CHANNELS-1:0]};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      fill_count   <= '0;
      wp           <= 1'b0;
      rp           <= 1'b0;
      q_count      <= 2'd0;
    end else begin
      if (accept) begin
        if (!trigger) begin
          fill_count <= n_cur;
        end else if (overlap_half) begin
          window_start <= start_wrap;
          fill_count   <= n_cur - half;
        end else begin
          window_start <= '0;
          fill_count   <= '0;
        end
      end
      if (push) begin
        q_start[wp] <= window_start;
        q_n[wp]     <= n_cur;
        wp          <= ~wp;
      end
      if (job_pop) begin
        rp <= ~rp;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, job_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> q_count != 2'd2)
    else $error("job queue overflow");
  assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("job popped from empty queue");
  assert property (@(posedge clk) disable iff (rst) accept |-> !reading)
    else $error("sample written during window pass");

endmodule

// ===== sv/emgwf_back.sv =====
// ----------------------------------------------------------------------------
// emgwf_back
// Window pass over the store, then per-channel mean, deviation and max.
// ----------------------------------------------------------------------------
module emgwf_back import emgwf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int CHANNELS   = CHANNELS_DEF,
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int NW = $clog2(WINDOW_MAX + 1),
  localparam int EW = SAMPLE_W * CHANNELS + LABEL_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  logic [AW-1:0]       job_start,
  input  logic [NW-1:0]       job_n,
  output logic                job_pop,
  output logic                reading,
  output logic [AW-1:0]       rd_addr,
  input  logic [EW-1:0]       rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          channel_index,
  output logic [15:0]         mean_abs,
  output logic [15:0]         stdev_abs,
  output logic [7:0]          max_abs,
  output logic [LABEL_W-1:0]  window_label,
  output logic                last_channel
);

  localparam int S1W  = NW + 7;
  localparam int S2W  = NW + 14;
  localparam int NUMW = 2 * NW + 14;
  localparam int DENW = 2 * NW;
  localparam int QDW  = NUMW + 16;
  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DRAIN, ST_MUL, ST_SUB,
    ST_MEAN, ST_VAR, ST_ROOT, ST_EMIT
  } state_t;

  state_t         state;
  logic [NW-1:0]  n;
  logic [NW-1:0]  rd_idx;
  logic           rd_pend;
  logic           rd_first;
  logic [CHW-1:0] ch;
  logic [LABEL_W-1:0] label;

  logic [S1W-1:0]      s1 [CHANNELS];
  logic [S2W-1:0]      s2 [CHANNELS];
  logic [SAMPLE_W-1:0] mx [CHANNELS];

  logic [NUMW-1:0] prod_a, prod_b, num;
  logic [DENW-1:0] den;
  logic [15:0]     mean_r;
  logic [15:0]     sd_r;

  logic            div_start, div_busy, div_done;
  logic [QDW-1:0]  div_dividend, div_quotient;
  logic [DENW-1:0] div_divisor;
  logic            sq_start, sq_busy, sq_done;
  logic [QDW/2-1:0] sq_root;

  assign job_pop = (state == ST_IDLE) && job_valid;
  assign reading = state == ST_READ;

  assign div_start    = (state == ST_SUB) || ((state == ST_MEAN) && div_done);
  assign div_dividend = (state == ST_SUB) ? QDW'({s1[ch], 8'd0}) : {num, 16'd0};
  assign div_divisor  = (state == ST_SUB) ? DENW'(n) : den;
  assign sq_start     = (state == ST_VAR) && div_done;

  emgwf_div #(.DW(QDW), .VW(DENW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  emgwf_sqrt #(.SW(QDW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (div_quotient),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // per-lane accumulation of the words coming back from the store
  always_ff @(posedge clk) begin
    if (job_pop) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s1[c] <= '0;
        s2[c] <= '0;
        mx[c] <= '0;
      end
    end else if (rd_pend) begin
      for (int c = 0; c < CHANNELS; c++) begin
        logic [SAMPLE_W-1:0] a;
        a = abs8(rd_data[SAMPLE_W*c +: SAMPLE_W]);
        s1[c] <= s1[c] + S1W'(a);
        s2[c] <= s2[c] + S2W'(a) * S2W'(a);
        if (a > mx[c]) begin
          mx[c] <= a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      rd_first  <= 1'b0;
      out_valid <= 1'b0;
      ch        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= 1'b0;
      if (rd_pend && rd_first) begin
        label    <= rd_data[SAMPLE_W*CHANNELS +: LABEL_W];
        rd_first <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            n        <= job_n;
            rd_addr  <= job_start;
            rd_idx   <= '0;
            rd_first <= 1'b1;
            ch       <= '0;
            state    <= ST_READ;
          end
        end
        ST_READ: begin
          rd_pend <= 1'b1;
          rd_idx  <= rd_idx + 1'b1;
          rd_addr <= (rd_addr == AW'(WINDOW_MAX - 1)) ? '0 : rd_addr + 1'b1;
          if (rd_idx == n - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_a <= NUMW'(n) * NUMW'(s2[ch]);
          prod_b <= NUMW'(s1[ch]) * NUMW'(s1[ch]);
          den    <= DENW'(n) * DENW'(n - 1'b1);
          state  <= ST_SUB;
        end
        ST_SUB: begin
          num   <= prod_a - prod_b;
          state <= ST_MEAN;
        end
        ST_MEAN: begin
          if (div_done) begin
            mean_r <= div_quotient[15:0];
            state  <= ST_VAR;
          end
        end
        ST_VAR: begin
          if (div_done) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            sd_r  <= sq_root[15:0];
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            channel_index <= 3'(ch);
            mean_abs      <= mean_r;
            stdev_abs     <= sd_r;
            max_abs       <= mx[ch];
            window_label  <= label;
            last_channel  <= ch == CHW'(CHANNELS - 1);
            if (ch == CHW'(CHANNELS - 1)) begin
              state <= ST_IDLE;
            end else begin
              ch    <= ch + 1'b1;
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst) sq_start |-> !sq_busy)
    else $error("root unit restarted while busy");
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_MUL) |-> !rd_pend && !rd_first)
    else $error("arithmetic started before window pass finished");

endmodule

// ===== sv/emg_window_feature_extractor.sv =====
// ----------------------------------------------------------------------------
// emg_window_feature_extractor
// Windowed mean, deviation and peak of |x| over an 8-channel EMG stream.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    sample_ch0..sample_ch7, sample_label
//  output    out_valid / out_ready  channel_index, mean_abs, stdev_abs,
//                                   max_abs, window_label, last_channel
//  config    cfg_write              cfg_index, cfg_data
//
// A sample is taken while the job queue is empty and no window pass runs.
// A closing sample queues a window job; input then stalls until that job has
// left the queue and for the pass over the store (one store read a cycle).
// Per channel the shared divider runs twice and the root unit once; an output
// stall holds the next channel. No clearing pass after reset; the store is
// only read where written.
// ----------------------------------------------------------------------------
module emg_window_feature_extractor import emgwf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [7:0]     sample_ch0,
  input  logic signed [7:0]     sample_ch1,
  input  logic signed [7:0]     sample_ch2,
  input  logic signed [7:0]     sample_ch3,
  input  logic signed [7:0]     sample_ch4,
  input  logic signed [7:0]     sample_ch5,
  input  logic signed [7:0]     sample_ch6,
  input  logic signed [7:0]     sample_ch7,
  input  logic signed [7:0]     sample_label,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            channel_index,
  output logic [15:0]           mean_abs,
  output logic [15:0]           stdev_abs,
  output logic [7:0]            max_abs,
  output logic signed [7:0]     window_label,
  output logic                  last_channel,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam int EW = SAMPLE_W * CHANNELS + LABEL_W;

  logic [CFG_DATA_W-1:0] window_length;
  logic                  overlap_half;

  logic                  job_valid, job_pop, reading;
  logic [AW-1:0]         job_start, rd_addr;
  logic [NW-1:0]         job_n;
  logic [EW-1:0]         rd_data;
  logic [SAMPLE_W*PORT_CHANNELS-1:0] samples;
  logic [LABEL_W-1:0]    label_out;

  assign samples = {sample_ch7, sample_ch6, sample_ch5, sample_ch4,
                    sample_ch3, sample_ch2, sample_ch1, sample_ch0};
  assign window_label = label_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      overlap_half  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_OVERLAP_HALF:  overlap_half  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  emgwf_front #(.WINDOW_MAX(WINDOW_MAX), .CHANNELS(CHANNELS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .samples       (samples),
    .label         (sample_label),
    .window_length (window_length),
    .overlap_half  (overlap_half),
    .job_valid     (job_valid),
    .job_start     (job_start),
    .job_n         (job_n),
    .job_pop       (job_pop),
    .reading       (reading),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  emgwf_back #(.WINDOW_MAX(WINDOW_MAX), .CHANNELS(CHANNELS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_start     (job_start),
    .job_n         (job_n),
    .job_pop       (job_pop),
    .reading       (reading),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .mean_abs      (mean_abs),
    .stdev_abs     (stdev_abs),
    .max_abs       (max_abs),
    .window_label  (label_out),
    .last_channel  (last_channel)
  );

endmodule
